// File: hw/rtl/sbc_pkg.sv
package sbc_pkg;

    localparam int ENTRIES_DEF = 16;
    localparam int SID_W       = 16;
    localparam int BID_W       = 4;
    localparam int KIND_W      = 2;
    localparam int DATA_W      = 24;

    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_UPDATE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_LK_SID = 2'd2;
    localparam logic [KIND_W-1:0] KIND_LK_BID = 2'd3;

    localparam logic [SID_W-1:0] SID_MISS = '1;
    localparam logic [BID_W-1:0] BID_MISS = '1;

    typedef struct packed {
        logic [SID_W-1:0] sid;
        logic [BID_W-1:0] bid;
    } t_entry;

endpackage

// File: hw/rtl/session_buffer_cam.sv
// Session/buffer table with two-way lookup.
// Slave channel (i_s_*): one request per transfer; tuser carries the kind
// (insert, update by buffer id, session lookup, buffer lookup), tdata the
// session id and buffer id. Master channel (o_m_*): one result per request;
// tuser is the ok flag, tdata the found session id and found buffer id,
// all ones where nothing was found or the kind returns no value.
// The pairs live in a synchronous RAM with a registered read port; valid
// marks sit in flip-flops. A request walks the RAM one entry per cycle and
// stops at the first valid match (or, for an insert, the first free entry).
// From acceptance, the walk runs until a match or the last entry; the result
// then passes through a result register to the output register.
// One request is in flight at a time; the next is accepted as soon as the
// result has been moved to the output register, even if it is not yet taken.
// Reset (synchronous, active low) clears all valid marks and the output
// valid flag; RAM contents are left as they are. When the receiver stalls,
// the result holds on the master channel; a finished result waits internally.
module session_buffer_cam #(
    parameter int ENTRIES = sbc_pkg::ENTRIES_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_s_tvalid,
    output logic                      o_s_tready,
    input  logic [sbc_pkg::DATA_W-1:0] i_s_tdata,  // [15:0] session, [19:16] buffer
    input  logic [sbc_pkg::KIND_W-1:0] i_s_tuser,  // [1:0] kind
    output logic                      o_m_tvalid,
    input  logic                      i_m_tready,
    output logic [sbc_pkg::DATA_W-1:0] o_m_tdata,  // [15:0] found_session, [19:16] found_buffer
    output logic                      o_m_tuser    // [0] ok
);
    import sbc_pkg::*;

    localparam int AW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW   = $clog2(ENTRIES + 1);
    localparam int PADW = DATA_W - SID_W - BID_W;

    localparam logic [AW-1:0] LAST_IDX = AW'(ENTRIES - 1);
    localparam logic [CW-1:0] END_CNT  = CW'(ENTRIES);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]        r_state, n_state;
    logic [ENTRIES-1:0] r_valid;
    t_entry            r_mem [ENTRIES];
    t_entry            r_rd;

    logic [KIND_W-1:0] r_kind;
    logic [SID_W-1:0]  r_sid;
    logic [BID_W-1:0]  r_bid;

    logic [CW-1:0]     r_issue;
    logic              r_cmp_vld;
    logic [AW-1:0]     r_cmp_idx;

    logic              r_res_ok;
    logic [SID_W-1:0]  r_res_sid;
    logic [BID_W-1:0]  r_res_bid;

    logic              r_o_valid;
    logic              r_o_ok;
    logic [SID_W-1:0]  r_o_sid;
    logic [BID_W-1:0]  r_o_bid;

    logic w_accept;
    logic w_issue;
    logic w_ent_vld;
    logic w_match;
    logic w_last;
    logic w_write;
    logic w_out_free;

    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_out_free = !r_o_valid || i_m_tready;
    assign w_issue    = (r_state == ST_SCAN) && (r_issue != END_CNT);
    assign w_ent_vld  = r_valid[r_cmp_idx];

    always_comb begin
        case (r_kind)
            KIND_INSERT: w_match = !w_ent_vld;
            KIND_UPDATE: w_match = w_ent_vld && (r_rd.bid == r_bid);
            KIND_LK_SID: w_match = w_ent_vld && (r_rd.bid == r_bid);
            KIND_LK_BID: w_match = w_ent_vld && (r_rd.sid == r_sid);
            default:     w_match = 1'b0;
        endcase
    end

    assign w_last  = r_cmp_vld && (w_match || (r_cmp_idx == LAST_IDX));
    assign w_write = r_cmp_vld && w_match &&
                     ((r_kind == KIND_INSERT) || (r_kind == KIND_UPDATE));

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (w_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_valid   <= '0;
            r_cmp_vld <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cmp_vld <= w_issue && !w_last;
            if (w_write && (r_kind == KIND_INSERT)) begin
                r_valid[r_cmp_idx] <= 1'b1;
            end
            if ((r_state == ST_DONE) && w_out_free) begin
                r_o_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // The walk issues one read per cycle and compares each entry once it is
    // back in the read register. The only write lands at the end of a walk,
    // before the next request is accepted, so no forwarding is needed.
    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_rd <= r_mem[r_issue[AW-1:0]];
        end
        if (w_write) begin
            r_mem[r_cmp_idx] <= '{sid: r_sid, bid: r_bid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_kind  <= i_s_tuser;
            r_sid   <= i_s_tdata[SID_W-1:0];
            r_bid   <= i_s_tdata[SID_W +: BID_W];
            r_issue <= '0;
        end else if (w_issue) begin
            r_issue <= r_issue + CW'(1);
        end
        if (w_issue) begin
            r_cmp_idx <= r_issue[AW-1:0];
        end
        if (w_last) begin
            r_res_ok  <= w_match;
            r_res_sid <= (w_match && (r_kind == KIND_LK_SID)) ? r_rd.sid : SID_MISS;
            r_res_bid <= (w_match && (r_kind == KIND_LK_BID)) ? r_rd.bid : BID_MISS;
        end
        if ((r_state == ST_DONE) && w_out_free) begin
            r_o_ok  <= r_res_ok;
            r_o_sid <= r_res_sid;
            r_o_bid <= r_res_bid;
        end
    end

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_o_valid;
    assign o_m_tuser  = r_o_ok;
    assign o_m_tdata  = {{PADW{1'b0}}, r_o_bid, r_o_sid};

    // An insert only ever claims an entry that was free.
    a_insert_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_write && (r_kind == KIND_INSERT)) |-> !w_ent_vld)
        else $error("insert wrote over a valid entry");

    // Entries are never released once written.
    a_valid_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> ($countones(r_valid) >= $past($countones(r_valid))))
        else $error("valid entry count decreased");

    // A failed request always reports all ones in both value fields.
    a_miss_ones: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser) |-> (o_m_tdata[SID_W+BID_W-1:0] == '1))
        else $error("miss result with a value field not all ones");

    // A walk never compares past the last entry.
    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_issue <= END_CNT))
        else $error("entry walk ran past the table");

endmodule
